FILE: design/bbep_pkg.sv
// Shared constants, breakpoint ROM and fraction scaling for the band emissive power block.
`default_nettype none
package bbep_pkg;

  localparam int LtW      = 16;  // breakpoint width, micrometre-kelvin
  localparam int FvW      = 17;  // stored fraction width, units of 1e-5
  localparam int RomSlots = 128;
  localparam int XW       = 46;  // lambda*T product, Q22.24
  localparam int XIntW    = 22;
  localparam int XFracW   = 24;
  localparam int DxW      = 40;
  localparam int EbW      = 37;  // sigma*T^4, Q.4
  localparam int SigmaW   = 30;
  localparam longint RomScale = 100000;
  localparam logic [SigmaW-1:0] SigmaQ54 = 30'd1021483845;

  localparam logic [LtW-1:0] LtRom [RomSlots] = '{
    16'd1000, 16'd1100, 16'd1200, 16'd1300, 16'd1400, 16'd1500, 16'd1600, 16'd1700,
    16'd1800, 16'd1900, 16'd2000, 16'd2100, 16'd2200, 16'd2300, 16'd2400, 16'd2500,
    16'd2600, 16'd2700, 16'd2800, 16'd2900, 16'd3000, 16'd3100, 16'd3200, 16'd3300,
    16'd3400, 16'd3500, 16'd3600, 16'd3700, 16'd3800, 16'd3900, 16'd4000, 16'd4100,
    16'd4200, 16'd4300, 16'd4400, 16'd4500, 16'd4600, 16'd4700, 16'd4800, 16'd4900,
    16'd5000, 16'd5100, 16'd5200, 16'd5300, 16'd5400, 16'd5500, 16'd5600, 16'd5700,
    16'd5800, 16'd5900, 16'd6000, 16'd6100, 16'd6200, 16'd6300, 16'd6400, 16'd6500,
    16'd6600, 16'd6700, 16'd6800, 16'd6900, 16'd7000, 16'd7100, 16'd7200, 16'd7300,
    16'd7400, 16'd7500, 16'd7600, 16'd7700, 16'd7800, 16'd7900, 16'd8000, 16'd8100,
    16'd8200, 16'd8300, 16'd8400, 16'd8500, 16'd8600, 16'd8700, 16'd8800, 16'd8900,
    16'd9000, 16'd9100, 16'd9200, 16'd9300, 16'd9400, 16'd9500, 16'd9600, 16'd9700,
    16'd9800, 16'd9900, 16'd10000, 16'd12000, 16'd15000, 16'd20000, 16'd30000,
    16'd40000, 16'd50000,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [FvW-1:0] FvRom [RomSlots] = '{
    17'd32, 17'd91, 17'd213, 17'd432, 17'd779, 17'd1280, 17'd1972, 17'd2853,
    17'd3934, 17'd5210, 17'd6672, 17'd8305, 17'd10088, 17'd12002, 17'd14025,
    17'd16135, 17'd18311, 17'd20535, 17'd22788, 17'd25055, 17'd27322, 17'd29576,
    17'd31809, 17'd34009, 17'd36172, 17'd38290, 17'd40359, 17'd42375, 17'd44336,
    17'd46240, 17'd48085, 17'd49872, 17'd51599, 17'd53267, 17'd54877, 17'd56429,
    17'd57925, 17'd59366, 17'd60753, 17'd62088, 17'd63372, 17'd64606, 17'd65794,
    17'd66935, 17'd68033, 17'd69087, 17'd70101, 17'd71076, 17'd72012, 17'd72913,
    17'd73778, 17'd74610, 17'd75410, 17'd76180, 17'd76920, 17'd77631, 17'd78316,
    17'd78975, 17'd79609, 17'd80219, 17'd80807, 17'd81373, 17'd81918, 17'd82443,
    17'd82949, 17'd83436, 17'd83906, 17'd84359, 17'd84796, 17'd85218, 17'd85625,
    17'd86017, 17'd86396, 17'd86762, 17'd87115, 17'd87456, 17'd87786, 17'd88105,
    17'd88413, 17'd88711, 17'd88999, 17'd89277, 17'd89547, 17'd89807, 17'd90060,
    17'd90304, 17'd90541, 17'd90770, 17'd90992, 17'd91207, 17'd91415, 17'd94505,
    17'd96893, 17'd98555, 17'd99529, 17'd99792, 17'd99890,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  // round(v * 2^fb / 1e5)
  function automatic longint frac_q(input longint v, input int fb);
    return ((v << fb) + (RomScale / 2)) / RomScale;
  endfunction

endpackage
`default_nettype wire

FILE: design/bbep_frac.sv
// Emission fraction lookup: breakpoint search, interpolation and pipelined segment divide.
`default_nettype none
module bbep_frac
  import bbep_pkg::*;
#(
  parameter int TABLE_ENTRIES = 97,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [XW-1:0]            x,
  output logic [FRACTION_BITS:0]   frac
);

  localparam int FW   = FRACTION_BITS + 1;
  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int NS   = TABLE_ENTRIES - 1;
  localparam int MW   = FW + LtW;

  logic [LtW-1:0] lt_tab [TABLE_ENTRIES];
  logic [FW-1:0]  fq_tab [TABLE_ENTRIES];

  for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_tab
    assign lt_tab[j] = LtRom[j];
    assign fq_tab[j] = FW'(frac_q(longint'(FvRom[j]), FRACTION_BITS));
  end

  // stage 1: compare against every breakpoint
  logic [XIntW-1:0] xi;
  logic [NS-1:0]    cmp1;
  logic             below1, above1;
  logic [XW-1:0]    x1;

  assign xi = x[XW-1 -: XIntW];

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= x;
      below1 <= (xi < XIntW'(lt_tab[0])) ||
                (xi == XIntW'(lt_tab[0]) && x[XFracW-1:0] == '0);
      above1 <= xi >= XIntW'(lt_tab[TABLE_ENTRIES-1]);
      for (int j = 0; j < NS; j++) begin
        cmp1[j] <= xi < XIntW'(lt_tab[j+1]);
      end
    end
  end

  // stage 2: first segment whose upper breakpoint lies above x
  logic            seg_next, seg2;
  logic [IdxW-1:0] idx_next, idx2;
  logic [XW-1:0]   x2;

  always_comb begin
    seg_next = 1'b0;
    idx_next = IdxW'(TABLE_ENTRIES - 1);
    if (below1) begin
      idx_next = '0;
    end else if (!above1) begin
      for (int j = NS - 1; j >= 0; j--) begin
        if (cmp1[j]) begin
          seg_next = 1'b1;
          idx_next = IdxW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg2 <= seg_next;
      idx2 <= idx_next;
      x2   <= x1;
    end
  end

  // stage 3: segment ends and offsets
  logic [IdxW-1:0] idx_hi;
  logic [LtW-1:0]  lo, hi;
  logic [FW-1:0]   f0, f1;
  logic [XW-1:0]   dx_full;
  logic            degen_next;
  logic [FW-1:0]   df3, f03;
  logic [DxW-1:0]  dx3;
  logic [LtW-1:0]  d3;
  logic            dg3;

  always_comb begin
    idx_hi  = (idx2 == IdxW'(TABLE_ENTRIES - 1)) ? idx2 : idx2 + 1'b1;
    lo      = lt_tab[idx2];
    hi      = lt_tab[idx_hi];
    f0      = fq_tab[idx2];
    f1      = fq_tab[idx_hi];
    degen_next = !seg2 || (hi <= lo) || (f1 <= f0) ||
                 (x2[XW-1 -: XIntW] < XIntW'(lo));
    dx_full = x2 - {XIntW'(lo), {XFracW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f03 <= f0;
      dg3 <= degen_next;
      df3 <= f1 - f0;
      dx3 <= dx_full[DxW-1:0];
      d3  <= hi - lo;
    end
  end

  // stage 4: partial products of df * dx
  logic [FW+LtW-1:0]    ph4;
  logic [FW+XFracW-1:0] pl4;
  logic [FW-1:0]        f04;
  logic [LtW-1:0]       d4;
  logic                 dg4;

  always_ff @(posedge clk) begin
    if (en) begin
      ph4 <= df3 * dx3[DxW-1:XFracW];
      pl4 <= df3 * dx3[XFracW-1:0];
      f04 <= f03;
      d4  <= d3;
      dg4 <= dg3;
    end
  end

  // stage 5 and on: floor(df*dx / 2^24) then restoring divide by segment width
  logic [MW-1:0]  rem [FW+1];
  logic [FW-1:0]  quo [FW+1];
  logic [LtW-1:0] dv  [FW+1];
  logic [FW-1:0]  fb  [FW+1];
  logic           dg  [FW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= MW'(ph4) + MW'(pl4[FW+XFracW-1:XFracW]);
      quo[0] <= '0;
      dv[0]  <= d4;
      fb[0]  <= f04;
      dg[0]  <= dg4;
      for (int k = 0; k < FW; k++) begin
        if (rem[k] >= (MW'(dv[k]) << (FW - 1 - k))) begin
          rem[k+1] <= rem[k] - (MW'(dv[k]) << (FW - 1 - k));
          quo[k+1] <= quo[k] | (FW'(1) << (FW - 1 - k));
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
        dv[k+1] <= dv[k];
        fb[k+1] <= fb[k];
        dg[k+1] <= dg[k];
      end
      frac <= dg[FW] ? fb[FW] : fb[FW] + quo[FW];
    end
  end

endmodule
`default_nettype wire

FILE: design/blackbody_band_emissive_power.sv
// Top level: black-body band emissive power, one cell temperature per cycle unless stalled.
//
// Input channel: temperature (Q14.8 kelvin) and last_cell, taken when in_valid is
// high and in_stall low. Output channel: band_power, band_fraction, saturated and
// last_out, taken when out_valid is high and out_stall low. One result per
// transaction, in order.
// Configuration: APB-style writes to full_spectrum (0x0), band_lower_um (0x4) and
// band_upper_um (0x8); change them only while the pipeline is empty.
// The pipeline depth is set by the fraction path: breakpoint compare, encode,
// segment fetch, partial products, then one restoring-divide step per quotient
// bit. The sigma*T^4 path (square, square, sigma multiply) runs alongside and
// is delayed to meet it.
// Throughput: one transaction per cycle. The whole pipeline advances together;
// it holds only when a result sits in the output register and out_stall is high,
// and in_stall is raised for exactly those cycles.
// Reset: pipeline valids and out_valid cleared, full_spectrum set to 1 and the
// band edges cleared.
`default_nettype none
module blackbody_band_emissive_power
  import bbep_pkg::*;
#(
  parameter int TABLE_ENTRIES = 97,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [21:0]        temperature,
  input  logic               last_cell,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] band_power,
  output logic signed [17:0] band_fraction,
  output logic               saturated,
  output logic               last_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int FW       = FRACTION_BITS + 1;
  localparam int FracLat  = FW + 6;        // x register to fraction register
  localparam int EbLine   = FracLat - 3;   // eb ready at stage 3
  localparam int PipeLen  = FracLat + 3;
  localparam int DiffW    = 26;
  localparam int ProdW    = EbW + FW;
  localparam int RndPos   = 4 + FRACTION_BITS;
  localparam int PwW      = ProdW + 1 - RndPos;
  localparam logic [1:0] RegFull  = 2'd0;
  localparam logic [1:0] RegLower = 2'd1;
  localparam logic [1:0] RegUpper = 2'd2;

  // configuration registers
  logic        full_spectrum;
  logic [23:0] band_lower_um, band_upper_um;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_spectrum <= 1'b1;
      band_lower_um <= '0;
      band_upper_um <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegFull:  full_spectrum <= pwdata[0];
        RegLower: band_lower_um <= pwdata[23:0];
        RegUpper: band_upper_um <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegFull:  prdata = {31'b0, full_spectrum};
      RegLower: prdata = {8'b0, band_lower_um};
      RegUpper: prdata = {8'b0, band_upper_um};
      default:  prdata = '0;
    endcase
  end

  // global advance: hold only when the output register is full and stalled
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // valid and end-of-sweep mark travel with the data
  logic vpipe [PipeLen];
  logic lpipe [PipeLen];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PipeLen; k++) vpipe[k] <= 1'b0;
    end else if (en) begin
      vpipe[0] <= in_valid;
      for (int k = 1; k < PipeLen; k++) vpipe[k] <= vpipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpipe[0] <= last_cell;
      for (int k = 1; k < PipeLen; k++) lpipe[k] <= lpipe[k-1];
    end
  end

  // stage 0: T^2 and both lambda*T products
  logic [43:0]   tt;
  logic [XW-1:0] xu, xl;

  always_ff @(posedge clk) begin
    if (en) begin
      tt <= temperature * temperature;
      xu <= band_upper_um * temperature;
      xl <= band_lower_um * temperature;
    end
  end

  // sigma*T^4 path: T^4 in Q.8, then two 32x30 halves, then the Q.4 sum
  logic [63:0]         t4;
  logic [61:0]         ph, pl;
  logic [62:0]         eb_sum;
  logic [EbW-1:0]      ebl [EbLine+1];

  assign eb_sum = {1'b0, ph} + 63'(pl[61:32]);

  always_ff @(posedge clk) begin
    if (en) begin
      t4     <= tt[43:12] * tt[43:12];
      ph     <= t4[63:32] * SigmaQ54;
      pl     <= t4[31:0] * SigmaQ54;
      ebl[0] <= eb_sum[62:26];
      for (int k = 1; k <= EbLine; k++) ebl[k] <= ebl[k-1];
    end
  end

  // fraction lookups for the two band edges
  logic [FW-1:0] f_up, f_lo;

  bbep_frac #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_frac_up (
    .clk  (clk),
    .en   (en),
    .x    (xu),
    .frac (f_up)
  );

  bbep_frac #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_frac_lo (
    .clk  (clk),
    .en   (en),
    .x    (xl),
    .frac (f_lo)
  );

  // stage A: signed difference and its magnitude
  logic [FW-1:0]    fp, fn;
  logic [DiffW-1:0] diff;
  logic [FW-1:0]    mag_a;
  logic             neg_a;
  logic [17:0]      frac_a;
  logic [EbW-1:0]   eb_a;

  always_comb begin
    fp   = full_spectrum ? (FW'(1) << FRACTION_BITS) : f_up;
    fn   = full_spectrum ? '0 : f_lo;
    diff = DiffW'(fp) - DiffW'(fn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= fn > fp;
      mag_a  <= (fn > fp) ? fn - fp : fp - fn;
      frac_a <= diff[17:0];
      eb_a   <= ebl[EbLine];
    end
  end

  // stage B: Eb * |fraction|
  logic [ProdW-1:0] prod_b;
  logic             neg_b;
  logic [17:0]      frac_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b <= eb_a * mag_a;
      neg_b  <= neg_a;
      frac_b <= frac_a;
    end
  end

  // output register: round half up on the magnitude, saturate, apply sign
  logic [ProdW:0] rnd;
  logic [PwW-1:0] pw;
  logic           sat_next;
  logic [32:0]    mag_out;

  always_comb begin
    rnd      = {1'b0, prod_b} + ((ProdW+1)'(1) << (RndPos - 1));
    pw       = rnd[ProdW:RndPos];
    sat_next = neg_b ? (pw > PwW'(33'h100000000)) : (pw > PwW'(33'h0FFFFFFFF));
    if (sat_next) begin
      mag_out = neg_b ? 33'h100000000 : 33'h0FFFFFFFF;
    end else begin
      mag_out = pw[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[PipeLen-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      band_power    <= neg_b ? -$signed(mag_out) : $signed(mag_out);
      band_fraction <= $signed(frac_b);
      saturated     <= sat_next;
      last_out      <= lpipe[PipeLen-1];
    end
  end

  // a clipped result sits on one of the two bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (band_power == 33'sh0FFFFFFFF || band_power == -33'sh100000000))
    else $error("saturated result off its bound");

  // input held back only while a result waits under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a held result stays on the port
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(band_power) && $stable(last_out))
    else $error("stalled result changed");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule
`default_nettype wire
